// ===== sv/stepper_trapezoid_ramp_top_assert.svh =====
// Assertion macros for the checker file of the ramp generator.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STEPPER_TRAPEZOID_RAMP_TOP_ASSERT_SVH
`define STEPPER_TRAPEZOID_RAMP_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define STR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define STR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/str_pkg.sv =====
package str_pkg;

  // Default values of the top-level parameters.
  localparam int DEF_COUNT_WIDTH      = 24;
  localparam int DEF_TICKS_PER_SECOND = 1000;

  // Field widths.
  localparam int ACTION_W   = 3;
  localparam int MODE_W     = 2;
  localparam int LEN_W      = 16;
  localparam int TGT_W      = 9;
  localparam int STEP_W     = 16;
  localparam int SPEED_W    = 17;
  localparam int RAMP_W     = 12;
  localparam int ACCEL_W    = 13;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Fixed-point shifts: mm to 1/131072 mm of two wheels, and speed to rate.
  localparam int LEN_SHIFT  = 17;
  localparam int RATE_SHIFT = 8;
  localparam int Y_SHIFT    = 8;

  // Width of a squared speed, of the shared dividend and of the clamped
  // magnitude of the remaining distance.
  localparam int SQ_W  = 2 * SPEED_W;
  localparam int DVD_W = LEN_W + LEN_SHIFT;
  localparam int MAG_W = 43;

  // Register reset values and limits.
  localparam logic [STEP_W-1:0]  STEP_LENGTH_RST = 16'd19661;
  localparam logic [SPEED_W-1:0] FLOOR_SPEED_RST = 17'd2560;
  localparam logic [RAMP_W-1:0]  RAMP_STEP_RST   = 12'd384;
  localparam logic [SPEED_W-1:0] SPEED_CAP       = 17'd128000;
  localparam logic [TGT_W-1:0]   TGT_MAX         = 9'd500;
  localparam logic [RATE_W-1:0]  RATE_MAX        = 16'hFFFF;
  localparam logic [MAG_W-1:0]   MAG_MAX         = {MAG_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 2'd2;

  // Move modes; any other code runs as a constant-speed move.
  localparam logic [MODE_W-1:0] MODE_ACCEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECEL = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 3'd0,
    ACT_TICK  = 3'd1,
    ACT_RIGHT = 3'd2,
    ACT_LEFT  = 3'd3,
    ACT_STOP  = 3'd4
  } action_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [STEP_W-1:0]  step_length;
    logic [SPEED_W-1:0] floor_speed;
    logic [RAMP_W-1:0]  ramp_step;
  } cfg_t;

endpackage

// ===== sv/str_cfg.sv =====
module str_cfg import str_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [STEP_W-1:0]  step_length_r;
  logic [SPEED_W-1:0] floor_speed_r;
  logic [SPEED_W-1:0] floor_speed_nxt;
  logic [RAMP_W-1:0]  ramp_step_r;

  // The floor speed is held to the speed cap when written.
  always_comb begin
    if (cfg_wdata > SPEED_CAP) begin
      floor_speed_nxt = SPEED_CAP;
    end else begin
      floor_speed_nxt = cfg_wdata;
    end
  end

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r <= STEP_LENGTH_RST;
      floor_speed_r <= FLOOR_SPEED_RST;
      ramp_step_r   <= RAMP_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_LENGTH: step_length_r <= cfg_wdata[STEP_W-1:0];
        CFG_FLOOR_SPEED: floor_speed_r <= floor_speed_nxt;
        CFG_RAMP_STEP:   ramp_step_r   <= cfg_wdata[RAMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.step_length = step_length_r;
  assign cfg.floor_speed = floor_speed_r;
  assign cfg.ramp_step   = ramp_step_r;

endmodule

// ===== sv/str_unit.sv =====
module str_unit import str_pkg::*; #(
  parameter int A_W = 64,
  parameter int B_W = 22,
  parameter int Q_W = DVD_W,
  parameter int D_W = STEP_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  alu_req_t       req,
  input  logic [A_W-1:0] opa,
  input  logic [B_W-1:0] opb,
  input  logic [Q_W-1:0] dvd,
  input  logic [D_W-1:0] dvs,
  output logic           done,
  output logic [A_W-1:0] prod,
  output logic [Q_W-1:0] quot
);

  localparam int SUM_W = A_W + 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             run_r;
  logic             done_r;
  alu_op_t          op_r;
  logic [A_W-1:0]   acc_r;
  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   dvs_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;

  logic [D_W:0]     shift_in;
  logic [SUM_W-1:0] add_x;
  logic [SUM_W-1:0] add_y;
  logic             add_sub;
  logic [SUM_W-1:0] add_s;
  logic             fits;
  logic             last;

  // One shared adder: accumulate a shifted multiplicand, or trial-subtract
  // the divisor from the partial remainder.
  always_comb begin
    shift_in = {rem_r, q_r[Q_W-1]};
    if (op_r == ALU_DIV) begin
      add_x   = SUM_W'(shift_in);
      add_y   = SUM_W'(dvs_r);
      add_sub = 1'b1;
    end else begin
      add_x   = {1'b0, acc_r};
      add_y   = b_r[0] ? {1'b0, a_r} : '0;
      add_sub = 1'b0;
    end
    add_s = add_x + (add_sub ? ~add_y : add_y) + SUM_W'(add_sub);
    fits  = ~add_s[SUM_W-1];
    if (op_r == ALU_DIV) begin
      last = (cnt_r == CNT_W'(1));
    end else begin
      last = (b_r == '0);
    end
  end

  // Run and completion control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && last) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Operand load and one multiplier bit or one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= '0;
      a_r   <= opa;
      b_r   <= opb;
      rem_r <= '0;
      q_r   <= dvd;
      dvs_r <= dvs;
      cnt_r <= CNT_W'(Q_W);
    end else if (run_r) begin
      if (op_r == ALU_DIV) begin
        rem_r <= fits ? add_s[D_W-1:0] : shift_in[D_W-1:0];
        q_r   <= {q_r[Q_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
      end else begin
        acc_r <= add_s[A_W-1:0];
        a_r   <= a_r << 1;
        b_r   <= b_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
  assign quot = q_r;

endmodule

// ===== sv/stepper_trapezoid_ramp_top.sv =====
// Channel   Direction  Handshake             Payload
// in_       request    in_valid / in_ready   action, move_mode, move_length, target_speed
// out_      result     out_valid / out_ready step_rate, current_speed, moving, braking,
//                                            move_done
// cfg_      write      cfg_we                cfg_index, cfg_wdata
//
// One request at a time: in_ready is high only while the block is idle.
// A stop or a request while no move runs needs no divide; a request during a
// move waits on the 33-bit divide for the step rate in the shared unit.
// A start adds a second 33-bit divide for the step goal; a decelerate tick
// before braking adds up to four multiplies by operands of up to K_W bits.
// Reset is synchronous and active low; no clearing pass follows it.
// A result stalled on out_ready holds the block until it is taken.
module stepper_trapezoid_ramp_top import str_pkg::*; #(
  parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH,
  parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [MODE_W-1:0]     in_move_mode,
  input  logic [LEN_W-1:0]      in_move_length,
  input  logic [TGT_W-1:0]      in_target_speed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RATE_W-1:0]     out_step_rate,
  output logic [SPEED_W-1:0]    out_current_speed,
  output logic                  out_moving,
  output logic                  out_braking,
  output logic                  out_move_done
);

  localparam int GOAL_W = COUNT_WIDTH + 1;
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int K_W    = TPS_W + RAMP_W;
  localparam int A_W    = MAG_W + K_W;
  localparam int B_W    = K_W;
  localparam int P_W    = GOAL_W + STEP_W;
  localparam int REM_W  = ((P_W > DVD_W) ? P_W : DVD_W) + 1;
  localparam int RM_W   = (REM_W > MAG_W) ? REM_W : MAG_W + 1;
  localparam int GQ_W   = (GOAL_W > DVD_W) ? GOAL_W : DVD_W;
  localparam int SW     = SPEED_W + 2;
  localparam logic [K_W-1:0] TPS_K = K_W'(TICKS_PER_SECOND);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_GOAL  = 12'b0000_0000_0010,
    ST_PULSE = 12'b0000_0000_0100,
    ST_MVV   = 12'b0000_0000_1000,
    ST_MFF   = 12'b0000_0001_0000,
    ST_MSP   = 12'b0000_0010_0000,
    ST_REM   = 12'b0000_0100_0000,
    ST_MRK   = 12'b0000_1000_0000,
    ST_SPEED = 12'b0001_0000_0000,
    ST_RATE  = 12'b0010_0000_0000,
    ST_RDIV  = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r;

  // Move state.
  logic [SPEED_W-1:0]        speed_r;
  logic [SPEED_W-1:0]        ceil_r;
  logic [SPEED_W-1:0]        floor_now_r;
  logic signed [ACCEL_W-1:0] accel_r;
  logic [COUNT_WIDTH-1:0]    right_r;
  logic [COUNT_WIDTH-1:0]    left_r;
  logic [GOAL_W-1:0]         goal_r;
  logic [LEN_W-1:0]          len_r;
  logic [MODE_W-1:0]         mode_r;
  logic                      active_r;
  logic                      brake_r;
  logic                      done_r;
  logic [RATE_W-1:0]         rate_r;

  // Braking check scratch.
  logic [SQ_W-1:0]           vv_r;
  logic [SQ_W-1:0]           ff_r;
  logic signed [REM_W-1:0]   rem_r;
  logic signed [SQ_W:0]      ydiff_r;
  logic [SQ_W-1:0]           ymag_r;
  logic                      gt_r;

  cfg_t                      cfg;
  alu_req_t                  alu_req;
  logic [A_W-1:0]            alu_opa;
  logic [B_W-1:0]            alu_opb;
  logic [DVD_W-1:0]          alu_dvd;
  logic                      alu_done;
  logic [A_W-1:0]            alu_prod;
  logic [DVD_W-1:0]          alu_quot;

  action_t                   action;
  logic [TGT_W-1:0]          tgt_sat;
  logic [SPEED_W-1:0]        ceil_val;
  logic [K_W-1:0]            k_val;
  logic [GOAL_W-1:0]         step_sum;
  logic [GOAL_W-1:0]         goal_sat;
  logic                      tick_check;
  logic                      rate_div;

  logic                      rem_neg;
  logic                      rem_pos;
  logic [REM_W-1:0]          rem_abs;
  logic [RM_W-1:0]           rem_abs_w;
  logic [MAG_W-1:0]          rem_mag;
  logic                      y_neg;
  logic [SQ_W-1:0]           y_abs;
  logic                      need_mul;
  logic                      far_rem;
  logic                      cmp_gt;
  logic [A_W-1:0]            y_full;
  logic                      far_mul;

  logic signed [SW-1:0]      spd_sum;
  logic signed [SW-1:0]      spd_hi;
  logic signed [SW-1:0]      spd_lo;
  logic [SPEED_W-1:0]        spd_new;

  str_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  str_unit #(
    .A_W (A_W),
    .B_W (B_W),
    .Q_W (DVD_W),
    .D_W (STEP_W)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_opa),
    .opb   (alu_opb),
    .dvd   (alu_dvd),
    .dvs   (cfg.step_length),
    .done  (alu_done),
    .prod  (alu_prod),
    .quot  (alu_quot)
  );

  // Request decode and fixed helpers.
  always_comb begin
    action     = action_t'(in_action);
    tgt_sat    = (in_target_speed > TGT_MAX) ? TGT_MAX : in_target_speed;
    ceil_val   = {tgt_sat, {RATE_SHIFT{1'b0}}};
    k_val      = K_W'(cfg.ramp_step) * TPS_K;
    step_sum   = {1'b0, right_r} + {1'b0, left_r};
    tick_check = active_r && (mode_r == MODE_DECEL) && !brake_r;
    rate_div   = active_r && (speed_r != '0) && (cfg.step_length != '0);
    if (GQ_W'(alu_quot) > GQ_W'({GOAL_W{1'b1}})) begin
      goal_sat = '1;
    end else begin
      goal_sat = GOAL_W'(alu_quot);
    end
  end

  // Sign and size of the remaining distance and of the squared-speed gap.
  always_comb begin
    rem_neg   = rem_r[REM_W-1];
    rem_pos   = !rem_neg && (rem_r != '0);
    rem_abs   = rem_neg ? REM_W'(-rem_r) : REM_W'(rem_r);
    rem_abs_w = RM_W'(rem_abs);
    rem_mag   = (rem_abs_w > RM_W'(MAG_MAX)) ? MAG_MAX : rem_abs_w[MAG_W-1:0];
    y_neg     = ydiff_r[SQ_W];
    y_abs     = y_neg ? SQ_W'(-ydiff_r) : SQ_W'(ydiff_r);
    need_mul  = 1'b0;
    far_rem   = 1'b0;
    cmp_gt    = 1'b0;
    if (cfg.ramp_step == '0) begin
      far_rem = y_neg;
    end else if (rem_pos) begin
      if (y_neg) begin
        far_rem = 1'b1;
      end else begin
        need_mul = 1'b1;
      end
    end else if (y_neg) begin
      need_mul = 1'b1;
      cmp_gt   = 1'b1;
    end
    y_full  = A_W'({ymag_r, {Y_SHIFT{1'b0}}});
    far_mul = gt_r ? (y_full > alu_prod) : (y_full < alu_prod);
  end

  // Speed update: add the acceleration, then clamp to ceiling and floor.
  always_comb begin
    spd_sum = $signed({2'b00, speed_r})
            + $signed({{(SW-ACCEL_W){accel_r[ACCEL_W-1]}}, accel_r});
    spd_hi  = (spd_sum > $signed({2'b00, ceil_r})) ? $signed({2'b00, ceil_r}) : spd_sum;
    spd_lo  = (spd_hi < $signed({2'b00, floor_now_r})) ? $signed({2'b00, floor_now_r})
                                                       : spd_hi;
    if (spd_lo < 0) begin
      spd_new = '0;
    end else if (spd_lo > $signed({2'b00, {SPEED_W{1'b1}}})) begin
      spd_new = '1;
    end else begin
      spd_new = spd_lo[SPEED_W-1:0];
    end
  end

  // Requests to the shared unit.
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    alu_dvd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (action == ACT_START && cfg.step_length != '0) begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_DIV;
            alu_dvd       = {in_move_length, {LEN_SHIFT{1'b0}}};
          end else if (action == ACT_TICK && tick_check) begin
            alu_req.start = 1'b1;
            alu_opa       = A_W'(speed_r);
            alu_opb       = B_W'(speed_r);
          end
        end
      end
      ST_MVV: begin
        if (alu_done) begin
          alu_req.start = 1'b1;
          alu_opa       = A_W'(cfg.floor_speed);
          alu_opb       = B_W'(cfg.floor_speed);
        end
      end
      ST_MFF: begin
        if (alu_done) begin
          alu_req.start = 1'b1;
          alu_opa       = A_W'(step_sum);
          alu_opb       = B_W'(cfg.step_length);
        end
      end
      ST_REM: begin
        if (need_mul) begin
          alu_req.start = 1'b1;
          alu_opa       = A_W'(rem_mag);
          alu_opb       = k_val;
        end
      end
      ST_RATE: begin
        if (rate_div) begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_dvd       = DVD_W'({speed_r, {RATE_SHIFT{1'b0}}});
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and move state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speed_r     <= '0;
      ceil_r      <= FLOOR_SPEED_RST;
      floor_now_r <= FLOOR_SPEED_RST;
      accel_r     <= '0;
      right_r     <= '0;
      left_r      <= '0;
      goal_r      <= '0;
      len_r       <= '0;
      mode_r      <= '0;
      active_r    <= 1'b0;
      brake_r     <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            done_r <= 1'b0;
            case (action)
              ACT_START: begin
                mode_r  <= in_move_mode;
                len_r   <= in_move_length;
                ceil_r  <= ceil_val;
                right_r <= '0;
                left_r  <= '0;
                brake_r <= 1'b0;
                if (in_move_mode == MODE_ACCEL) begin
                  accel_r     <= $signed({1'b0, cfg.ramp_step});
                  speed_r     <= cfg.floor_speed;
                  floor_now_r <= cfg.floor_speed;
                end else begin
                  accel_r     <= '0;
                  speed_r     <= ceil_val;
                  floor_now_r <= ceil_val;
                end
                if (cfg.step_length == '0) begin
                  goal_r   <= '1;
                  active_r <= 1'b1;
                  state_r  <= ST_RATE;
                end else begin
                  state_r <= ST_GOAL;
                end
              end
              ACT_TICK: begin
                if (tick_check) begin
                  state_r <= ST_MVV;
                end else if (active_r) begin
                  state_r <= ST_SPEED;
                end else begin
                  state_r <= ST_RATE;
                end
              end
              ACT_RIGHT: begin
                if (active_r) begin
                  if (right_r != '1) begin
                    right_r <= right_r + COUNT_WIDTH'(1);
                  end
                  state_r <= ST_PULSE;
                end else begin
                  state_r <= ST_RATE;
                end
              end
              ACT_LEFT: begin
                if (active_r) begin
                  if (left_r != '1) begin
                    left_r <= left_r + COUNT_WIDTH'(1);
                  end
                  state_r <= ST_PULSE;
                end else begin
                  state_r <= ST_RATE;
                end
              end
              ACT_STOP: begin
                active_r <= 1'b0;
                state_r  <= ST_RATE;
              end
              default: begin
                state_r <= ST_RATE;
              end
            endcase
          end
        end
        ST_GOAL: begin
          if (alu_done) begin
            goal_r <= goal_sat;
            if (goal_sat == '0) begin
              active_r <= 1'b0;
              done_r   <= 1'b1;
            end else begin
              active_r <= 1'b1;
            end
            state_r <= ST_RATE;
          end
        end
        ST_PULSE: begin
          if (step_sum >= goal_r) begin
            active_r <= 1'b0;
            done_r   <= 1'b1;
          end
          state_r <= ST_RATE;
        end
        ST_MVV: begin
          if (alu_done) begin
            vv_r    <= alu_prod[SQ_W-1:0];
            state_r <= ST_MFF;
          end
        end
        ST_MFF: begin
          if (alu_done) begin
            ff_r    <= alu_prod[SQ_W-1:0];
            state_r <= ST_MSP;
          end
        end
        ST_MSP: begin
          if (alu_done) begin
            rem_r   <= REM_W'({len_r, {LEN_SHIFT{1'b0}}}) - REM_W'(alu_prod);
            ydiff_r <= {1'b0, vv_r} - {1'b0, ff_r};
            state_r <= ST_REM;
          end
        end
        ST_REM: begin
          ymag_r <= y_abs;
          gt_r   <= cmp_gt;
          if (need_mul) begin
            state_r <= ST_MRK;
          end else begin
            if (!far_rem) begin
              accel_r     <= -$signed({1'b0, cfg.ramp_step});
              floor_now_r <= cfg.floor_speed;
              brake_r     <= 1'b1;
            end
            state_r <= ST_SPEED;
          end
        end
        ST_MRK: begin
          if (alu_done) begin
            if (!far_mul) begin
              accel_r     <= -$signed({1'b0, cfg.ramp_step});
              floor_now_r <= cfg.floor_speed;
              brake_r     <= 1'b1;
            end
            state_r <= ST_SPEED;
          end
        end
        ST_SPEED: begin
          speed_r <= spd_new;
          state_r <= ST_RATE;
        end
        ST_RATE: begin
          if (rate_div) begin
            state_r <= ST_RDIV;
          end else begin
            rate_r  <= (active_r && speed_r != '0) ? RATE_MAX : '0;
            state_r <= ST_OUT;
          end
        end
        ST_RDIV: begin
          if (alu_done) begin
            rate_r  <= (alu_quot > DVD_W'(RATE_MAX)) ? RATE_MAX : alu_quot[RATE_W-1:0];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The result registers hold still while the result waits.
  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = (state_r == ST_OUT);
  assign out_step_rate     = rate_r;
  assign out_current_speed = speed_r;
  assign out_moving        = active_r;
  assign out_braking       = brake_r;
  assign out_move_done     = done_r;

endmodule

// ===== sv/str_chk.sv =====
`include "stepper_trapezoid_ramp_top_assert.svh"

module str_chk import str_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [ACTION_W-1:0]   in_action,
  input logic [MODE_W-1:0]     in_move_mode,
  input logic [LEN_W-1:0]      in_move_length,
  input logic [TGT_W-1:0]      in_target_speed,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [RATE_W-1:0]     out_step_rate,
  input logic [SPEED_W-1:0]    out_current_speed,
  input logic                  out_moving,
  input logic                  out_braking,
  input logic                  out_move_done
);

  // A stalled result keeps its values.
  `STR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_step_rate) && $stable(out_current_speed) && $stable(out_moving) && $stable(out_braking) && $stable(out_move_done), "stalled result changed")

  // The block takes one request at a time: never ready while a result waits.
  `STR_ASSERT_IMP(a_one_at_a_time, in_ready, !out_valid, "ready while a result is pending")

  // An accepted request makes the block busy in the next cycle.
  `STR_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready again straight after a request")

  // No move, no steps.
  `STR_ASSERT_IMP(a_rate_idle, out_valid && !out_moving, out_step_rate == '0, "step rate while not moving")

  // A completed move is no longer active.
  `STR_ASSERT_IMP(a_done_stops, out_valid && out_move_done, !out_moving, "move done yet still moving")

endmodule

bind stepper_trapezoid_ramp_top str_chk u_str_chk (.*);
